### hw/rtl/hmpi_pkg.sv
// shared types, constants and helpers of the hall motor pi speed controller
package hmpi_pkg;

    // default parameter values
    localparam int unsigned WINDOW_TICKS_DEF = 250;
    localparam int unsigned PWM_PERIOD_DEF   = 240;

    // field widths
    localparam int unsigned HALL_W   = 3;
    localparam int unsigned LINES_W  = 2;
    localparam int unsigned MEAS_W   = 12;
    localparam int unsigned SECTOR_W = 3;
    localparam int unsigned PWM_W    = 8;
    localparam int unsigned SPEED_W  = 34;

    // configuration register widths
    localparam int unsigned DESIRED_W = 10;
    localparam int unsigned PROP_W    = 32;
    localparam int unsigned INTEG_G_W = 24;
    localparam int unsigned STEP_W    = 36;

    // state widths
    localparam int unsigned DUTY_W  = 48;
    localparam int unsigned INTEG_W = 32;
    localparam int unsigned EDGE_W  = 16;
    localparam int unsigned TICK_W  = 8;

    // apb register file
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned PADDR_W  = 6;
    localparam int unsigned ADDR_LSB = 3;
    localparam int unsigned INDEX_W  = PADDR_W - ADDR_LSB;

    // item queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // fixed-point constants, duty in q0.48
    localparam logic [DUTY_W-1:0]         DUTY_START  = 48'd14073748835533;
    localparam logic [DUTY_W-1:0]         DUTY_MAX    = 48'd267401227875123;
    localparam logic signed [INTEG_W-1:0] INTEG_UPPER = 32'sd10;
    localparam logic [SPEED_W-1:0]        SPEED_MAX   = '1;
    localparam logic [DESIRED_W-1:0]      DESIRED_MAX = 10'd1000;
    localparam int unsigned               EDGE_REV_Q16 = 10922;
    localparam int unsigned               RPM_WINDOW   = 6000;
    localparam int unsigned               SPEED_K_W    = 26;

    // register reset values
    localparam logic [PROP_W-1:0]    PROP_GAIN_RST  = 32'd28147498;
    localparam logic [INTEG_G_W-1:0] INTEG_GAIN_RST = 24'd281475;
    localparam logic [STEP_W-1:0]    MAX_STEP_RST   = 36'd2814749767;

    // codes
    localparam logic [SECTOR_W-1:0] SECTOR_INVALID = 3'd6;
    localparam logic [LINES_W-1:0]  LINES_FAULT    = 2'b00;

    typedef enum logic
    {
        KIND_TICK = 1'b0,
        KIND_EDGE = 1'b1
    } kind_t;

    typedef enum logic [INDEX_W-1:0]
    {
        REG_TARGET_RPM = 3'd0,
        REG_RUN_ENABLE = 3'd1,
        REG_PROP_GAIN  = 3'd2,
        REG_INTEG_GAIN = 3'd3,
        REG_MAX_STEP   = 3'd4
    } reg_index_t;

    // configuration seen by the back part
    typedef struct packed
    {
        logic [DESIRED_W-1:0] target_rpm;
        logic                 run_enable;
        logic [PROP_W-1:0]    prop_gain;
        logic [INTEG_G_W-1:0] integ_gain;
        logic [STEP_W-1:0]    max_step;
    } cfg_t;

    // classified item held in the queue
    typedef struct packed
    {
        kind_t               kind;
        logic [HALL_W-1:0]   seq;
        logic [SECTOR_W-1:0] sector;
        logic                fault;
        logic [MEAS_W-1:0]   measured_speed;
    } item_t;

    // hall pattern h3h2h1 to sector, invalid patterns give the invalid code
    function automatic logic [SECTOR_W-1:0] sector_of(input logic [HALL_W-1:0] seq);
        case (seq)
            3'b100:  return 3'd0;
            3'b101:  return 3'd1;
            3'b001:  return 3'd2;
            3'b011:  return 3'd3;
            3'b010:  return 3'd4;
            3'b110:  return 3'd5;
            default: return SECTOR_INVALID;
        endcase
    endfunction

endpackage

### hw/rtl/hmpi_in_if.sv
// input item channel: hall edges and control ticks
interface hmpi_in_if;
    import hmpi_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [HALL_W-1:0]  hall_bits;
    logic [LINES_W-1:0] fault_lines;
    logic [MEAS_W-1:0]  measured_speed;

    modport source
    (
        output valid, req_type, hall_bits, fault_lines, measured_speed,
        input  ready
    );

    modport sink
    (
        input  valid, req_type, hall_bits, fault_lines, measured_speed,
        output ready
    );
endinterface

### hw/rtl/hmpi_out_if.sv
// result item channel: one item per running control tick
interface hmpi_out_if;
    import hmpi_pkg::*;

    logic                valid;
    logic                ready;
    logic [HALL_W-1:0]   hall_sequence;
    logic [SECTOR_W-1:0] hall_sector;
    logic [PWM_W-1:0]    pwm_match;
    logic                fault_flag;
    logic [SPEED_W-1:0]  speed_estimate;

    modport source
    (
        output valid, hall_sequence, hall_sector, pwm_match, fault_flag, speed_estimate,
        input  ready
    );

    modport sink
    (
        input  valid, hall_sequence, hall_sector, pwm_match, fault_flag, speed_estimate,
        output ready
    );
endinterface

### hw/rtl/hmpi_front.sv
// front part: accepts input items and classifies them for the queue
module hmpi_front
(
    hmpi_in_if.sink          item_in,
    input  logic             full,
    output logic             push,
    output hmpi_pkg::item_t  push_item
);
    import hmpi_pkg::*;

    logic [SECTOR_W-1:0] sector;

    // accept whenever the queue has room
    assign item_in.ready = !full;
    assign push          = item_in.valid && !full;

    // sector decode and fault check
    assign sector = sector_of(item_in.hall_bits);

    always_comb
    begin
        push_item.kind           = item_in.req_type ? KIND_EDGE : KIND_TICK;
        push_item.seq            = item_in.hall_bits;
        push_item.sector         = sector;
        push_item.fault          = (sector == SECTOR_INVALID) ||
                                   (item_in.fault_lines == LINES_FAULT);
        push_item.measured_speed = item_in.measured_speed;
    end
endmodule

### hw/rtl/hmpi_queue.sv
// short item queue between the front and back parts
module hmpi_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hmpi_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output hmpi_pkg::item_t  head
);
    import hmpi_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end
endmodule

### hw/rtl/hmpi_back.sv
// back part: loop state, pi pipeline and result register
module hmpi_back #(
    parameter int unsigned WINDOW_TICKS = hmpi_pkg::WINDOW_TICKS_DEF,
    parameter int unsigned PWM_PERIOD   = hmpi_pkg::PWM_PERIOD_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hmpi_pkg::cfg_t   cfg,
    input  logic             run_clear,
    input  logic             head_valid,
    input  hmpi_pkg::item_t  head,
    output logic             pop,
    hmpi_out_if.source       item_out
);
    import hmpi_pkg::*;

    localparam int unsigned ERR_W   = MEAS_W + 1;
    localparam int unsigned P_W     = PROP_W + 1 + ERR_W;
    localparam int unsigned Q_W     = INTEG_G_W + 1 + INTEG_W;
    localparam int unsigned ACC_W   = Q_W + 1;
    localparam int unsigned INC_W   = STEP_W + 1;
    localparam int unsigned DSUM_W  = DUTY_W + 2;
    localparam int unsigned SPROD_W = EDGE_W + SPEED_K_W;
    localparam int unsigned MPROD_W = DUTY_W + PWM_W;
    localparam logic [SPEED_K_W-1:0] SPEED_K =
        SPEED_K_W'((RPM_WINDOW / WINDOW_TICKS) * EDGE_REV_Q16);

    typedef struct packed
    {
        logic [HALL_W-1:0]   seq;
        logic [SECTOR_W-1:0] sector;
        logic                fault;
        logic                win;
    } meta_t;

    // loop state
    logic signed [INTEG_W-1:0] integral_reg;
    logic [EDGE_W-1:0]         edge_reg;
    logic [TICK_W-1:0]         tick_reg;
    logic                      fault_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic [SPEED_W-1:0]        speed_value_reg;

    // pipeline registers
    logic                      b_valid_reg;
    meta_t                     b_meta_reg;
    logic signed [ERR_W-1:0]   b_err_reg;
    logic signed [INTEG_W-1:0] b_sum_reg;
    logic [EDGE_W-1:0]         b_edges_reg;
    logic                      c_valid_reg;
    meta_t                     c_meta_reg;
    logic signed [P_W-1:0]     c_p_reg;
    logic signed [Q_W-1:0]     c_q_reg;
    logic [SPROD_W-1:0]        c_speed_reg;
    logic                      d_valid_reg;
    meta_t                     d_meta_reg;
    logic signed [INC_W-1:0]   d_inc_reg;
    logic [SPEED_W-1:0]        d_speed_reg;

    // result register
    logic                      out_valid_reg;
    logic [HALL_W-1:0]         seq_reg;
    logic [SECTOR_W-1:0]       sector_reg;
    logic [PWM_W-1:0]          match_reg;
    logic                      fault_out_reg;
    logic [SPEED_W-1:0]        speed_out_reg;

    // stage a signals
    logic                      advance;
    logic                      run_tick;
    logic                      edge_pop;
    logic                      stop_clear;
    logic signed [ERR_W-1:0]   err_a;
    logic signed [INTEG_W:0]   sum_wide;
    logic signed [INTEG_W-1:0] sum_sat;
    logic signed [INTEG_W-1:0] integral_next;
    logic [TICK_W:0]           tick_inc;
    logic                      win_a;
    logic                      fault_next;

    // later stage signals
    logic signed [P_W-1:0]     p_next;
    logic signed [Q_W-1:0]     q_next;
    logic [SPROD_W-1:0]        speed_prod_next;
    logic signed [ACC_W-1:0]   inc_full;
    logic signed [ACC_W-1:0]   lim_pos;
    logic signed [ACC_W-1:0]   lim_neg;
    logic signed [ACC_W-1:0]   inc_lim;
    logic [SPEED_W-1:0]        speed_sat_next;
    logic signed [DSUM_W-1:0]  duty_sum;
    logic [DUTY_W-1:0]         duty_next;
    logic [MPROD_W-1:0]        match_prod;

    // the whole pipeline moves when the result register can take an item
    assign advance    = !out_valid_reg || item_out.ready;
    assign pop        = advance && head_valid;
    assign run_tick   = pop && (head.kind == KIND_TICK) && cfg.run_enable;
    assign edge_pop   = pop && (head.kind == KIND_EDGE) && cfg.run_enable;
    assign stop_clear = run_clear || (pop && (head.kind == KIND_TICK) && !cfg.run_enable);

    // stage a: error, integral update, window count
    always_comb
    begin
        err_a    = $signed(ERR_W'(cfg.target_rpm)) - $signed(ERR_W'(head.measured_speed));
        sum_wide = (INTEG_W + 1)'(integral_reg) + (INTEG_W + 1)'(err_a);
        if (sum_wide[INTEG_W] && !sum_wide[INTEG_W-1])
        begin
            sum_sat = $signed({1'b1, {(INTEG_W - 1){1'b0}}});
        end
        else
        begin
            sum_sat = $signed(sum_wide[INTEG_W-1:0]);
        end
        integral_next = (sum_sat > INTEG_UPPER) ? INTEG_UPPER : sum_sat;
        tick_inc      = (TICK_W + 1)'(tick_reg) + (TICK_W + 1)'(1);
        win_a         = (tick_inc >= (TICK_W + 1)'(WINDOW_TICKS));
        fault_next    = fault_reg | head.fault;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            edge_reg     <= '0;
            tick_reg     <= '0;
            fault_reg    <= 1'b0;
        end
        else if (stop_clear)
        begin
            integral_reg <= '0;
            edge_reg     <= '0;
            tick_reg     <= '0;
        end
        else if (run_tick)
        begin
            integral_reg <= integral_next;
            fault_reg    <= fault_next;
            if (win_a)
            begin
                edge_reg <= '0;
                tick_reg <= '0;
            end
            else
            begin
                tick_reg <= tick_inc[TICK_W-1:0];
            end
        end
        else if (edge_pop && (edge_reg != '1))
        begin
            edge_reg <= edge_reg + EDGE_W'(1);
        end
    end

    // stage b: operands for the products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b_valid_reg <= run_tick;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_meta_reg  <= '{seq: head.seq, sector: head.sector, fault: fault_next, win: win_a};
            b_err_reg   <= err_a;
            b_sum_reg   <= sum_sat;
            b_edges_reg <= edge_reg;
        end
    end

    // stage c: gain products and window speed product
    always_comb
    begin
        p_next          = P_W'($signed({1'b0, cfg.prop_gain})) * P_W'(b_err_reg);
        q_next          = Q_W'($signed({1'b0, cfg.integ_gain})) * Q_W'(b_sum_reg);
        speed_prod_next = SPROD_W'(b_edges_reg) * SPROD_W'(SPEED_K);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_meta_reg  <= b_meta_reg;
            c_p_reg     <= p_next;
            c_q_reg     <= q_next;
            c_speed_reg <= speed_prod_next;
        end
    end

    // stage d: increment sum and step limit, speed saturation
    always_comb
    begin
        inc_full = ACC_W'(c_p_reg) + ACC_W'(c_q_reg);
        lim_pos  = $signed(ACC_W'(cfg.max_step));
        lim_neg  = -lim_pos;
        if (inc_full > lim_pos)
        begin
            inc_lim = lim_pos;
        end
        else if (inc_full < lim_neg)
        begin
            inc_lim = lim_neg;
        end
        else
        begin
            inc_lim = inc_full;
        end
        speed_sat_next = (c_speed_reg > SPROD_W'(SPEED_MAX)) ? SPEED_MAX
                                                              : c_speed_reg[SPEED_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            d_meta_reg  <= c_meta_reg;
            d_inc_reg   <= $signed(inc_lim[INC_W-1:0]);
            d_speed_reg <= speed_sat_next;
        end
    end

    // result stage: duty update and match count from the duty held before the tick
    always_comb
    begin
        duty_sum = $signed(DSUM_W'(duty_reg)) + DSUM_W'(d_inc_reg);
        if (duty_sum < 0)
        begin
            duty_next = '0;
        end
        else if (duty_sum > $signed(DSUM_W'(DUTY_MAX)))
        begin
            duty_next = DUTY_MAX;
        end
        else
        begin
            duty_next = duty_sum[DUTY_W-1:0];
        end
        match_prod = MPROD_W'(duty_reg) * MPROD_W'(PWM_W'(PWM_PERIOD));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            duty_reg        <= DUTY_START;
            speed_value_reg <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= d_valid_reg;
            end
            if (stop_clear)
            begin
                duty_reg        <= DUTY_START;
                speed_value_reg <= '0;
            end
            else if (advance && d_valid_reg)
            begin
                duty_reg <= duty_next;
                if (d_meta_reg.win)
                begin
                    speed_value_reg <= d_speed_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && d_valid_reg)
        begin
            seq_reg       <= d_meta_reg.seq;
            sector_reg    <= d_meta_reg.sector;
            match_reg     <= match_prod[MPROD_W-1:DUTY_W];
            fault_out_reg <= d_meta_reg.fault;
            speed_out_reg <= d_meta_reg.win ? d_speed_reg : speed_value_reg;
        end
    end

    // result channel
    assign item_out.valid          = out_valid_reg;
    assign item_out.hall_sequence  = seq_reg;
    assign item_out.hall_sector    = sector_reg;
    assign item_out.pwm_match      = match_reg;
    assign item_out.fault_flag     = fault_out_reg;
    assign item_out.speed_estimate = speed_out_reg;
endmodule

### hw/rtl/hall_motor_pi_speed_controller_core.sv
// top level of the hall motor pi speed controller with its apb register file
//
// channel   dir  handshake          carries
// item_in   in   valid/ready        req_type, hall_bits, fault_lines, measured_speed
// item_out  out  valid/ready        hall_sequence, hall_sector, pwm_match, fault_flag,
//                                   speed_estimate
// apb       in   psel/penable       register writes and reads, pready always high
//
// one item per cycle is taken while the result register is free or being drained
// a tick's result is registered in turn in the queue slot, operand stage, product stage
// and step limit stage, all ahead of the result register
// hall edges and stopped ticks pass through the queue and give no result
// a stalled result holds the back pipeline; the front keeps taking items until
// the two-entry queue fills
// rst_n clears all control state at once, with no clearing pass
module hall_motor_pi_speed_controller_core #(
    parameter int unsigned WINDOW_TICKS = hmpi_pkg::WINDOW_TICKS_DEF,
    parameter int unsigned PWM_PERIOD   = hmpi_pkg::PWM_PERIOD_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    hmpi_in_if.sink                      item_in,
    hmpi_out_if.source                   item_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hmpi_pkg::PADDR_W-1:0] paddr,
    input  logic [hmpi_pkg::DATA_W-1:0]  pwdata,
    output logic [hmpi_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import hmpi_pkg::*;

    cfg_t                 cfg_reg;
    logic                 wr_en;
    reg_index_t           reg_index;
    logic [DESIRED_W-1:0] desired_raw;
    logic                 run_clear;
    logic                 push;
    item_t                push_item;
    logic                 full;
    logic                 pop;
    logic                 head_valid;
    item_t                head;

    // register write decode
    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite;
    assign reg_index   = reg_index_t'(paddr[PADDR_W-1:ADDR_LSB]);
    assign desired_raw = pwdata[DESIRED_W-1:0];
    assign run_clear   = wr_en && (reg_index == REG_RUN_ENABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_rpm <= '0;
            cfg_reg.run_enable <= 1'b0;
            cfg_reg.prop_gain  <= PROP_GAIN_RST;
            cfg_reg.integ_gain <= INTEG_GAIN_RST;
            cfg_reg.max_step   <= MAX_STEP_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_TARGET_RPM:
                begin
                    cfg_reg.target_rpm <= (desired_raw > DESIRED_MAX) ? DESIRED_MAX
                                                                      : desired_raw;
                end
                REG_RUN_ENABLE: cfg_reg.run_enable <= pwdata[0];
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= pwdata[PROP_W-1:0];
                REG_INTEG_GAIN: cfg_reg.integ_gain <= pwdata[INTEG_G_W-1:0];
                REG_MAX_STEP:   cfg_reg.max_step   <= pwdata[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_index)
            REG_TARGET_RPM: prdata = DATA_W'(cfg_reg.target_rpm);
            REG_RUN_ENABLE: prdata = DATA_W'(cfg_reg.run_enable);
            REG_PROP_GAIN:  prdata = DATA_W'(cfg_reg.prop_gain);
            REG_INTEG_GAIN: prdata = DATA_W'(cfg_reg.integ_gain);
            REG_MAX_STEP:   prdata = DATA_W'(cfg_reg.max_step);
            default:        prdata = '0;
        endcase
    end

    // front: accept and classify
    hmpi_front u_front
    (
        .item_in   (item_in),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    // queue between front and back
    hmpi_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: loop state and pi pipeline
    hmpi_back #(
        .WINDOW_TICKS (WINDOW_TICKS),
        .PWM_PERIOD   (PWM_PERIOD)
    ) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .run_clear  (run_clear),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .item_out   (item_out)
    );
endmodule

### hw/rtl/hmpi_checker.sv
// port-level checks of the result channel, bound to the top level
module hmpi_checker #(
    parameter int unsigned PWM_PERIOD = hmpi_pkg::PWM_PERIOD_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [hmpi_pkg::HALL_W-1:0]   hall_sequence,
    input logic [hmpi_pkg::SECTOR_W-1:0] hall_sector,
    input logic [hmpi_pkg::PWM_W-1:0]    pwm_match,
    input logic                          fault_flag,
    input logic [hmpi_pkg::SPEED_W-1:0]  speed_estimate
);
    import hmpi_pkg::*;

    logic seen_fault_reg;

    // remembers a fault shown on any delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_fault_reg <= 1'b0;
        end
        else if (out_valid && out_ready && fault_flag)
        begin
            seen_fault_reg <= 1'b1;
        end
    end

    // duty stays below one, so the match count stays below the period
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, pwm_match} < (PWM_W + 1)'(PWM_PERIOD)))
        else $error("pwm match reached the period");

    // sector agrees with the raw hall sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hall_sector == sector_of(hall_sequence)))
        else $error("hall sector does not match hall sequence");

    // an invalid pattern always shows the fault
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (hall_sector == SECTOR_INVALID)) |-> fault_flag)
        else $error("invalid hall pattern without fault flag");

    // the fault stays set once shown
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && seen_fault_reg) |-> fault_flag)
        else $error("fault flag dropped after being shown");

    // a stalled item holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(hall_sequence) &&
            $stable(hall_sector) && $stable(pwm_match) && $stable(fault_flag) &&
            $stable(speed_estimate)))
        else $error("result item changed while stalled");
endmodule

bind hall_motor_pi_speed_controller_core hmpi_checker #(
    .PWM_PERIOD (PWM_PERIOD)
) u_hmpi_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (item_out.valid),
    .out_ready      (item_out.ready),
    .hall_sequence  (item_out.hall_sequence),
    .hall_sector    (item_out.hall_sector),
    .pwm_match      (item_out.pwm_match),
    .fault_flag     (item_out.fault_flag),
    .speed_estimate (item_out.speed_estimate)
);

### sim/tb_top.sv
// self-checking testbench of the hall motor pi speed controller core
`timescale 1ns / 100ps

module tb_top;
    import hmpi_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned IDLE_LIMIT    = 2000;
    localparam int unsigned RAND_PHASES   = 5;
    localparam int unsigned TAIL_ITEMS    = 20;
    localparam longint      INTEG_FLOOR   = -(64'sd1 <<< 31);
    localparam longint      DUTY_CAP      = longint'(DUTY_MAX);
    localparam logic [INDEX_W-1:0] REG_SPARE = 3'd5;

    // one input item and one result item
    typedef struct packed
    {
        kind_t              req_type;
        logic [HALL_W-1:0]  hall_bits;
        logic [LINES_W-1:0] fault_lines;
        logic [MEAS_W-1:0]  measured_speed;
    } ctrl_item_t;

    typedef struct packed
    {
        logic [HALL_W-1:0]   hall_sequence;
        logic [SECTOR_W-1:0] hall_sector;
        logic [PWM_W-1:0]    pwm_match;
        logic                fault_flag;
        logic [SPEED_W-1:0]  speed_estimate;
    } ctrl_result_t;

    // speed loop predictor plus the store of results still to come
    class pi_loop_scoreboard;
        logic [DESIRED_W-1:0] want_rpm;
        logic                 run;
        logic [PROP_W-1:0]    kp;
        logic [INTEG_G_W-1:0] ki;
        logic [STEP_W-1:0]    step_lim;
        logic [DUTY_W-1:0]    duty;
        longint               integ;
        logic [EDGE_W-1:0]    edges;
        logic [TICK_W-1:0]    ticks;
        logic [SPEED_W-1:0]   speed;
        logic                 fault;
        ctrl_result_t         expected_q[$];
        int unsigned          mismatches;
        int unsigned          results_seen;
        int unsigned          running_ticks;
        int unsigned          counted_edges;
        int unsigned          stopped_ticks;
        int unsigned          windows;

        function new();
            want_rpm = '0;
            run      = 1'b0;
            kp       = PROP_GAIN_RST;
            ki       = INTEG_GAIN_RST;
            step_lim = MAX_STEP_RST;
            fault    = 1'b0;
            clear_loop();
        endfunction

        function void clear_loop();
            duty  = DUTY_START;
            integ = 0;
            edges = '0;
            ticks = '0;
            speed = '0;
        endfunction

        function void write_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_TARGET_RPM:
                    want_rpm = (value[DESIRED_W-1:0] > DESIRED_MAX) ?
                               DESIRED_MAX : value[DESIRED_W-1:0];
                REG_RUN_ENABLE:
                begin
                    run = value[0];
                    clear_loop();
                end
                REG_PROP_GAIN:  kp = value[PROP_W-1:0];
                REG_INTEG_GAIN: ki = value[INTEG_G_W-1:0];
                REG_MAX_STEP:   step_lim = value[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        // h3h2h1 pattern to commutation sector
        function logic [SECTOR_W-1:0] pattern_sector(logic [HALL_W-1:0] pattern);
            case (pattern)
                3'd1:    return 3'd2;
                3'd2:    return 3'd4;
                3'd3:    return 3'd3;
                3'd4:    return 3'd0;
                3'd5:    return 3'd1;
                3'd6:    return 3'd5;
                default: return SECTOR_INVALID;
            endcase
        endfunction

        function void note_item(ctrl_item_t it);
            ctrl_result_t       r;
            logic [63:0]        prod;
            longint             want_s, meas_s, err, sum, kp_s, ki_s, inc, lim, d;
            longint unsigned    s;

            // hall edges only count while running
            if (it.req_type == KIND_EDGE)
            begin
                if (run)
                begin
                    counted_edges++;
                    if (edges != '1)
                        edges = edges + 1'b1;
                end
                return;
            end
            if (!run)
            begin
                stopped_ticks++;
                clear_loop();
                return;
            end

            r.hall_sequence = it.hall_bits;
            r.hall_sector   = pattern_sector(it.hall_bits);
            if (r.hall_sector == SECTOR_INVALID || it.fault_lines == LINES_FAULT)
                fault = 1'b1;

            // match point from the duty held before this tick
            prod        = 64'(duty) * 64'(PWM_PERIOD_DEF);
            r.pwm_match = prod[DUTY_W +: PWM_W];

            // pi step, increment taken before the upper integral clamp
            want_s = want_rpm;
            meas_s = it.measured_speed;
            err    = want_s - meas_s;
            sum    = integ + err;
            if (sum < INTEG_FLOOR)
                sum = INTEG_FLOOR;
            kp_s = kp;
            ki_s = ki;
            inc  = kp_s * err + ki_s * sum;
            if (sum > INTEG_UPPER)
                sum = INTEG_UPPER;
            integ = sum;
            lim   = step_lim;
            if (inc > lim)
                inc = lim;
            else if (inc < -lim)
                inc = -lim;
            d = duty;
            d = d + inc;
            if (d < 0)
                d = 0;
            if (d > DUTY_CAP)
                d = DUTY_CAP;
            duty = d[DUTY_W-1:0];

            // speed window
            ticks = ticks + 1'b1;
            if (ticks >= WINDOW_TICKS_DEF)
            begin
                s     = edges;
                s     = s * (RPM_WINDOW / WINDOW_TICKS_DEF) * EDGE_REV_Q16;
                speed = (s > SPEED_MAX) ? SPEED_MAX : s[SPEED_W-1:0];
                edges = '0;
                ticks = '0;
                windows++;
            end

            r.fault_flag     = fault;
            r.speed_estimate = speed;
            expected_q.push_back(r);
            running_ticks++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(ctrl_result_t got);
            ctrl_result_t want;

            if (expected_q.size() == 0)
            begin
                $display("%0t: result with none expected, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            compare_field("hall_sequence", want.hall_sequence, got.hall_sequence);
            compare_field("hall_sector", want.hall_sector, got.hall_sector);
            compare_field("pwm_match", want.pwm_match, got.pwm_match);
            compare_field("fault_flag", want.fault_flag, got.fault_flag);
            compare_field("speed_estimate", want.speed_estimate, got.speed_estimate);
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    hmpi_in_if  in_if();
    hmpi_out_if out_if();

    pi_loop_scoreboard sb;
    bit                pause_on;
    int unsigned       ready_hold;
    int unsigned       idle_cycles = 0;

    hall_motor_pi_speed_controller_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_in  (in_if),
        .item_out (out_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // gap length: mostly short, now and then long
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic int unsigned src_gap();
        if (!pause_on || $urandom_range(0, 99) < 55)
            return 0;
        return gap_len();
    endfunction

    function automatic ctrl_item_t mk_item(kind_t kind, logic [HALL_W-1:0] hall,
                                           logic [LINES_W-1:0] lines, logic [MEAS_W-1:0] meas);
        ctrl_item_t it;

        it.req_type       = kind;
        it.hall_bits      = hall;
        it.fault_lines    = lines;
        it.measured_speed = meas;
        return it;
    endfunction

    // random item, measured speed often close to the target
    function automatic ctrl_item_t rand_item(int unsigned edge_pct);
        ctrl_item_t  it;
        int unsigned pick;
        int          near_rpm;

        it.req_type    = ($urandom_range(0, 99) < edge_pct) ? KIND_EDGE : KIND_TICK;
        it.hall_bits   = ($urandom_range(0, 9) == 0) ? HALL_W'($urandom_range(0, 7)) :
                                                      HALL_W'($urandom_range(1, 6));
        it.fault_lines = ($urandom_range(0, 9) == 0) ? LINES_FAULT :
                                                      LINES_W'($urandom_range(1, 3));
        pick     = $urandom_range(0, 9);
        near_rpm = int'(sb.want_rpm) + int'($urandom_range(0, 40)) - 20;
        if (near_rpm < 0)
            near_rpm = 0;
        if (pick == 0)
            it.measured_speed = '0;
        else if (pick == 1)
            it.measured_speed = '1;
        else if (pick < 6)
            it.measured_speed = MEAS_W'(near_rpm);
        else
            it.measured_speed = MEAS_W'($urandom_range(0, 4095));
        return it;
    endfunction

    // item source, called at a falling edge and returning at one
    task automatic send_item(input ctrl_item_t it, input int unsigned gap);
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.req_type       <= it.req_type;
        in_if.hall_bits      <= it.hall_bits;
        in_if.fault_lines    <= it.fault_lines;
        in_if.measured_speed <= it.measured_speed;
        in_if.valid          <= 1'b1;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    // stop sending and let every pending result drain
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic reg_write(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {ADDR_LSB{1'b0}}};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [DESIRED_W-1:0] desired, input logic [PROP_W-1:0] kp,
                             input logic [INTEG_G_W-1:0] ki, input logic [STEP_W-1:0] step,
                             input logic run);
        reg_write(REG_TARGET_RPM, DATA_W'(desired));
        reg_write(REG_PROP_GAIN, DATA_W'(kp));
        reg_write(REG_INTEG_GAIN, DATA_W'(ki));
        reg_write(REG_MAX_STEP, DATA_W'(step));
        reg_write(REG_RUN_ENABLE, DATA_W'(run));
    endtask

    // result sink with random stalls
    initial
    begin
        out_if.ready = 1'b0;
        ready_hold   = 0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                ready_hold--;
                out_if.ready <= 1'b0;
            end
            else
            begin
                out_if.ready <= 1'b1;
                if (pause_on && $urandom_range(0, 99) < 25)
                    ready_hold = gap_len();
            end
        end
    end

    // result check at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
            sb.check_result({out_if.hall_sequence, out_if.hall_sector, out_if.pwm_match,
                             out_if.fault_flag, out_if.speed_estimate});
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if (!rst_n || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [DESIRED_W-1:0] pick_rpm;
        logic [PROP_W-1:0]    pick_kp;
        logic [INTEG_G_W-1:0] pick_ki;
        logic [STEP_W-1:0]    pick_step;
        int unsigned          phase_len;

        sb                   = new();
        pause_on             = 1'b1;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        in_if.valid          = 1'b0;
        in_if.req_type       = 1'b0;
        in_if.hall_bits      = '0;
        in_if.fault_lines    = '0;
        in_if.measured_speed = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: every valid pattern, speed extremes, target above range
        wait_idle();
        reg_write(REG_TARGET_RPM, 64'd1023);
        reg_write(REG_RUN_ENABLE, 64'd1);
        send_item(mk_item(KIND_TICK, 3'b100, 2'b11, 12'd0), src_gap());
        send_item(mk_item(KIND_TICK, 3'b101, 2'b01, 12'd4095), src_gap());
        send_item(mk_item(KIND_TICK, 3'b001, 2'b10, 12'd1000), src_gap());
        send_item(mk_item(KIND_EDGE, 3'b111, 2'b00, 12'd4095), src_gap());
        send_item(mk_item(KIND_EDGE, 3'b000, 2'b11, 12'd0), src_gap());
        send_item(mk_item(KIND_TICK, 3'b011, 2'b11, 12'd500), src_gap());
        send_item(mk_item(KIND_TICK, 3'b010, 2'b01, 12'd0), src_gap());
        send_item(mk_item(KIND_EDGE, 3'b110, 2'b10, 12'd7), src_gap());
        send_item(mk_item(KIND_TICK, 3'b110, 2'b10, 12'd4095), src_gap());

        // stopped: ticks and edges give nothing, unused register ignored
        wait_idle();
        reg_write(REG_RUN_ENABLE, 64'd0);
        send_item(mk_item(KIND_TICK, 3'b100, 2'b11, 12'd100), src_gap());
        send_item(mk_item(KIND_EDGE, 3'b101, 2'b11, 12'd0), src_gap());
        send_item(mk_item(KIND_TICK, 3'b000, 2'b00, 12'd0), src_gap());
        wait_idle();
        reg_write(REG_SPARE, '1);
        reg_write(REG_RUN_ENABLE, 64'd1);
        send_item(mk_item(KIND_EDGE, 3'b001, 2'b01, 12'd0), src_gap());
        send_item(mk_item(KIND_TICK, 3'b101, 2'b11, 12'd999), src_gap());

        // faults: invalid patterns, then both fault lines low
        send_item(mk_item(KIND_TICK, 3'b000, 2'b11, 12'd0), src_gap());
        send_item(mk_item(KIND_TICK, 3'b111, 2'b11, 12'd0), src_gap());
        send_item(mk_item(KIND_TICK, 3'b001, LINES_FAULT, 12'd0), src_gap());

        // random phases, the first long enough to close a speed window
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            pause_on = (ph % 3 != 2);
            case ($urandom_range(0, 4))
                0:       pick_rpm = '0;
                1:       pick_rpm = DESIRED_MAX;
                2:       pick_rpm = '1;
                default: pick_rpm = DESIRED_W'($urandom_range(0, 1023));
            endcase
            case ($urandom_range(0, 4))
                0:       pick_kp = '0;
                1:       pick_kp = '1;
                2:       pick_kp = PROP_GAIN_RST;
                default: pick_kp = $urandom;
            endcase
            case ($urandom_range(0, 4))
                0:       pick_ki = '0;
                1:       pick_ki = '1;
                2:       pick_ki = INTEG_GAIN_RST;
                default: pick_ki = INTEG_G_W'($urandom_range(0, 24'hFF_FFFF));
            endcase
            case ($urandom_range(0, 4))
                0:       pick_step = '0;
                1:       pick_step = '1;
                2:       pick_step = MAX_STEP_RST;
                default:
                begin
                    pick_step[31:0]        = $urandom;
                    pick_step[STEP_W-1:32] = (STEP_W - 32)'($urandom_range(0, 15));
                end
            endcase
            configure(pick_rpm, pick_kp, pick_ki, pick_step, (ph != 3));
            phase_len = (ph == 0) ? 340 : $urandom_range(10, 30);
            for (int k = 0; k < phase_len; k++)
            begin
                // sender holds off until the loop has fully drained
                if (ph == 0 && k == 170)
                    wait_idle();
                send_item(rand_item(20), src_gap());
            end
        end

        // short run on the default gains with stalls on both sides
        wait_idle();
        pause_on = 1'b1;
        configure(10'd500, PROP_GAIN_RST, INTEG_GAIN_RST, MAX_STEP_RST, 1'b1);
        for (int k = 0; k < TAIL_ITEMS; k++)
            send_item(rand_item(10), src_gap());

        // final drain
        in_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        $display("covered %0d running ticks, %0d counted hall edges, %0d stopped ticks",
                 sb.running_ticks, sb.counted_edges, sb.stopped_ticks);
        $display("checked %0d results over %0d speed windows, %0d mismatches",
                 sb.results_seen, sb.windows, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
